[src/sarc_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// sarc_pkg: shared types and constants of the summed-area rectangle counter
// Holds the field widths, the class codes, the register map, the controller
// states and the configuration bundle passed from the register file.
// ============================================================================
package sarc_pkg;

    // Width of one prefix entry and of one reported count.
    localparam int ENT_W = 21;
    // Width of a running row sum.
    localparam int SUM_W = 11;
    // Width of the size registers and of the rectangle coordinates.
    localparam int SIZE_W = 11;
    // Reset value of both size registers.
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;
    // One memory word packs the J, I and O prefix entries.
    localparam int WORD_W = 3 * ENT_W;

    // Register indexes, decoded from paddr[2].
    localparam logic REG_GRID_ROWS = 1'b0;
    localparam logic REG_GRID_COLS = 1'b1;

    // Load classes; the unused code counts as O.
    typedef enum logic [1:0] {
        KIND_J = 2'd0,
        KIND_I = 2'd1,
        KIND_O = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_QUERY,
        ST_QFIN
    } state_t;

    // Configuration seen by the core.
    typedef struct packed {
        logic [SIZE_W-1:0] grid_rows;
        logic [SIZE_W-1:0] grid_cols;
        logic              restart;
    } cfg_t;

endpackage

[src/sarc_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sarc_cfg: configuration register file
// APB-style slave holding the grid size registers. Any write also restarts
// the loading of the grid.
// ============================================================================
module sarc_cfg
    import sarc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output cfg_t             cfg
);

    logic [SIZE_W-1:0] grid_rows_reg;
    logic [SIZE_W-1:0] grid_cols_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= SIZE_RESET;
            grid_cols_reg <= SIZE_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_GRID_ROWS)
            begin
                grid_rows_reg <= pwdata[SIZE_W-1:0];
            end
            else
            begin
                grid_cols_reg <= pwdata[SIZE_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_GRID_COLS)
        begin
            prdata = {{(32-SIZE_W){1'b0}}, grid_cols_reg};
        end
        else
        begin
            prdata = {{(32-SIZE_W){1'b0}}, grid_rows_reg};
        end
    end

    assign cfg.grid_rows = grid_rows_reg;
    assign cfg.grid_cols = grid_cols_reg;
    assign cfg.restart   = wr_en;

endmodule
`default_nettype wire

[src/sarc_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sarc_mem: prefix table memory
// Simple dual-port synchronous RAM, one write and one registered read.
// ============================================================================
module sarc_mem #(
    parameter int DEPTH = 1048576,
    parameter int AW    = 20,
    parameter int DW    = 63
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic [DW-1:0]      rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[src/summed_area_rect_count.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// summed_area_rect_count: three-class summed-area table with rectangle counts
// Builds J/I/O prefix entries from a row-major cell stream and answers
// inclusive rectangle count queries by inclusion-exclusion.
// ============================================================================
// Usage:
//   A request is taken at a rising edge where start is high and busy is low.
//   mode 0 loads the next grid cell (class in cell_kind); mode 1 asks for the
//   counts inside rectangle top_row..bottom_row by left_col..right_col, all
//   one-based and inclusive.
//   A load reads the prefix entry above the cell and writes the new entry in
//   the next cycle, so busy is high for one cycle. A load past the end of
//   the grid is dropped and leaves busy low.
//   A valid query reads its four corner entries through the single read port
//   of the table, one per cycle, and accumulates them as they return: done
//   pulses after the QFIN state, and busy stays high through the QUERY and
//   QFIN states, so no new request is taken meanwhile. A rejected query
//   (empty, reversed, outside the grid or not yet loaded) answers with zero
//   counts and bad_query high in the very next cycle and keeps busy low.
//   Results appear on the count ports with the one-cycle done strobe and
//   hold until the next result; the receiver cannot stall them.
//   The APB port holds grid_rows (address 0) and grid_cols (address 4);
//   any write restarts loading at the first cell. Reset sets both sizes to
//   1024 and restarts loading; the table itself is not cleared.
// ============================================================================
module summed_area_rect_count
    import sarc_pkg::*;
#(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 1024
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              mode,
    input  wire logic [1:0]        cell_kind,
    input  wire logic [SIZE_W-1:0] top_row,
    input  wire logic [SIZE_W-1:0] left_col,
    input  wire logic [SIZE_W-1:0] bottom_row,
    input  wire logic [SIZE_W-1:0] right_col,
    output logic                   done,
    output logic [ENT_W-1:0]       count_j,
    output logic [ENT_W-1:0]       count_o,
    output logic [ENT_W-1:0]       count_i,
    output logic                   bad_query,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    // Position counters must hold the size itself (the end of the grid).
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int CW    = $clog2(MAX_COLS + 1);
    // Zero-based row and column indexes into the table.
    localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // Common width for comparing coordinates against sizes.
    localparam int WW0   = (RW > CW) ? RW : CW;
    localparam int WW    = (WW0 > SIZE_W) ? WW0 : SIZE_W;

    cfg_t cfg;

    state_t state_reg, state_next;

    logic [RW-1:0]    load_row_reg;
    logic [CW-1:0]    load_col_reg;
    logic             grid_done_reg;
    logic [SUM_W-1:0] row_sum_j_reg, row_sum_i_reg, row_sum_o_reg;
    logic [SUM_W-1:0] row_sum_j_next, row_sum_i_next, row_sum_o_next;
    logic             above_zero_reg;

    // Query corners, one-based; zero means the border.
    logic [RW-1:0]    q_top_m1_reg, q_bot_reg;
    logic [CW-1:0]    q_left_m1_reg, q_right_reg;
    logic [1:0]       term_reg;
    logic             term_zero_reg, term_neg_reg;
    logic [ENT_W-1:0] acc_j_reg, acc_i_reg, acc_o_reg;
    logic [ENT_W-1:0] acc_j_next, acc_i_next, acc_o_next;

    logic             done_reg, bad_reg;
    logic [ENT_W-1:0] cnt_j_reg, cnt_i_reg, cnt_o_reg;

    logic [RW-1:0]    rows_eff;
    logic [CW-1:0]    cols_eff;
    logic             accept;
    logic             load_ok;
    logic             q_bad;
    logic [WW-1:0]    qa, qb, qc, qd;

    logic [RW-1:0]    term_row1;
    logic [CW-1:0]    term_col1;
    logic             term_zero;

    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    logic [WORD_W-1:0] mem_wdata, mem_rdata;
    logic [ENT_W-1:0] rd_j, rd_i, rd_o;
    logic [ENT_W-1:0] ab_j, ab_i, ab_o;
    logic [ENT_W-1:0] tv_j, tv_i, tv_o;
    logic             acc_en;
    logic [CW-1:0]    col_inc;
    logic [RW-1:0]    row_inc;

    function automatic logic [AW-1:0] ent_addr(input logic [RIW-1:0] r,
                                               input logic [CIW-1:0] c);
        ent_addr = AW'(r) * AW'(MAX_COLS) + AW'(c);
    endfunction

    sarc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sarc_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (WORD_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // A size of zero acts as one; a size above the table acts as its maximum.
    always_comb
    begin
        if (cfg.grid_rows == '0)
        begin
            rows_eff = RW'(1);
        end
        else if (WW'(cfg.grid_rows) > WW'(MAX_ROWS))
        begin
            rows_eff = RW'(MAX_ROWS);
        end
        else
        begin
            rows_eff = RW'(cfg.grid_rows);
        end

        if (cfg.grid_cols == '0)
        begin
            cols_eff = CW'(1);
        end
        else if (WW'(cfg.grid_cols) > WW'(MAX_COLS))
        begin
            cols_eff = CW'(MAX_COLS);
        end
        else
        begin
            cols_eff = CW'(cfg.grid_cols);
        end
    end

    assign accept  = start && !busy;
    assign load_ok = !grid_done_reg && (load_row_reg < rows_eff) && (load_col_reg < cols_eff);

    // Query check. The last cell is loaded when it comes before the load
    // position in row-major order.
    assign qa = WW'(top_row);
    assign qb = WW'(left_col);
    assign qc = WW'(bottom_row);
    assign qd = WW'(right_col);

    always_comb
    begin
        q_bad = (qa == '0) || (qb == '0) || (qa > qc) || (qb > qd)
             || (qc > WW'(rows_eff)) || (qd > WW'(cols_eff));
        if (!q_bad && !grid_done_reg)
        begin
            if (!((qc <= WW'(load_row_reg))
                  || ((qc == WW'(load_row_reg) + WW'(1)) && (qd <= WW'(load_col_reg)))))
            begin
                q_bad = 1'b1;
            end
        end
    end

    // Running row sums after the current cell; an unknown class counts as O.
    always_comb
    begin
        row_sum_j_next = row_sum_j_reg;
        row_sum_i_next = row_sum_i_reg;
        row_sum_o_next = row_sum_o_reg;
        case (cell_kind)
            KIND_J:  row_sum_j_next = row_sum_j_reg + SUM_W'(1);
            KIND_I:  row_sum_i_next = row_sum_i_reg + SUM_W'(1);
            default: row_sum_o_next = row_sum_o_reg + SUM_W'(1);
        endcase
    end

    // Corner of the current inclusion-exclusion term: bit 0 picks the row
    // above the rectangle, bit 1 the column left of it.
    assign term_row1 = term_reg[0] ? q_top_m1_reg : q_bot_reg;
    assign term_col1 = term_reg[1] ? q_left_m1_reg : q_right_reg;
    assign term_zero = (term_row1 == '0) || (term_col1 == '0);

    assign rd_j = mem_rdata[3*ENT_W-1 -: ENT_W];
    assign rd_i = mem_rdata[2*ENT_W-1 -: ENT_W];
    assign rd_o = mem_rdata[ENT_W-1 -: ENT_W];

    // Entry above the loaded cell; the top border reads as zero.
    assign ab_j = above_zero_reg ? '0 : rd_j;
    assign ab_i = above_zero_reg ? '0 : rd_i;
    assign ab_o = above_zero_reg ? '0 : rd_o;

    assign mem_wdata = {ab_j + ENT_W'(row_sum_j_reg),
                        ab_i + ENT_W'(row_sum_i_reg),
                        ab_o + ENT_W'(row_sum_o_reg)};
    assign mem_waddr = ent_addr(RIW'(load_row_reg), CIW'(load_col_reg));

    // Term value returned by the memory, summed in with its sign.
    assign tv_j = term_zero_reg ? '0 : rd_j;
    assign tv_i = term_zero_reg ? '0 : rd_i;
    assign tv_o = term_zero_reg ? '0 : rd_o;
    assign acc_j_next = term_neg_reg ? (acc_j_reg - tv_j) : (acc_j_reg + tv_j);
    assign acc_i_next = term_neg_reg ? (acc_i_reg - tv_i) : (acc_i_reg + tv_i);
    assign acc_o_next = term_neg_reg ? (acc_o_reg - tv_o) : (acc_o_reg + tv_o);
    assign acc_en = ((state_reg == ST_QUERY) && (term_reg != 2'd0)) || (state_reg == ST_QFIN);

    assign col_inc = load_col_reg + CW'(1);
    assign row_inc = load_row_reg + RW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state, busy and memory port control.
    always_comb
    begin
        state_next = state_reg;
        busy       = 1'b1;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_raddr  = ent_addr(RIW'(term_row1 - RW'(1)), CIW'(term_col1 - CW'(1)));
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (!mode)
                    begin
                        if (load_ok)
                        begin
                            mem_re     = (load_row_reg != '0);
                            mem_raddr  = ent_addr(RIW'(load_row_reg - RW'(1)),
                                                  CIW'(load_col_reg));
                            state_next = ST_LOAD;
                        end
                    end
                    else if (!q_bad)
                    begin
                        state_next = ST_QUERY;
                    end
                end
            end
            ST_LOAD:
            begin
                mem_we     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_QUERY:
            begin
                mem_re = !term_zero;
                if (term_reg == 2'd3)
                begin
                    state_next = ST_QFIN;
                end
            end
            ST_QFIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Load position, row sums and completion flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_row_reg  <= '0;
            load_col_reg  <= '0;
            grid_done_reg <= 1'b0;
            row_sum_j_reg <= '0;
            row_sum_i_reg <= '0;
            row_sum_o_reg <= '0;
        end
        else if (cfg.restart)
        begin
            load_row_reg  <= '0;
            load_col_reg  <= '0;
            grid_done_reg <= 1'b0;
            row_sum_j_reg <= '0;
            row_sum_i_reg <= '0;
            row_sum_o_reg <= '0;
        end
        else if (accept && !mode && load_ok)
        begin
            row_sum_j_reg <= row_sum_j_next;
            row_sum_i_reg <= row_sum_i_next;
            row_sum_o_reg <= row_sum_o_next;
        end
        else if (state_reg == ST_LOAD)
        begin
            // The entry has been written with the sums; now step on.
            if (col_inc >= cols_eff)
            begin
                load_col_reg  <= '0;
                load_row_reg  <= row_inc;
                row_sum_j_reg <= '0;
                row_sum_i_reg <= '0;
                row_sum_o_reg <= '0;
                if (row_inc >= rows_eff)
                begin
                    grid_done_reg <= 1'b1;
                end
            end
            else
            begin
                load_col_reg <= col_inc;
            end
        end
    end

    // Query sequencing and accumulation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_reg <= 2'd0;
        end
        else if (accept)
        begin
            term_reg <= 2'd0;
        end
        else if (state_reg == ST_QUERY)
        begin
            term_reg <= term_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            above_zero_reg <= (load_row_reg == '0);
            q_top_m1_reg   <= RW'(qa - WW'(1));
            q_left_m1_reg  <= CW'(qb - WW'(1));
            q_bot_reg      <= RW'(qc);
            q_right_reg    <= CW'(qd);
            acc_j_reg      <= '0;
            acc_i_reg      <= '0;
            acc_o_reg      <= '0;
        end
        else if (acc_en)
        begin
            acc_j_reg <= acc_j_next;
            acc_i_reg <= acc_i_next;
            acc_o_reg <= acc_o_next;
        end
        if (state_reg == ST_QUERY)
        begin
            term_zero_reg <= term_zero;
            term_neg_reg  <= term_reg[0] ^ term_reg[1];
        end
    end

    // Result register: one-cycle strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (accept && mode && q_bad) || (state_reg == ST_QFIN);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && mode && q_bad)
        begin
            cnt_j_reg <= '0;
            cnt_i_reg <= '0;
            cnt_o_reg <= '0;
            bad_reg   <= 1'b1;
        end
        else if (state_reg == ST_QFIN)
        begin
            cnt_j_reg <= acc_j_next;
            cnt_i_reg <= acc_i_next;
            cnt_o_reg <= acc_o_next;
            bad_reg   <= 1'b0;
        end
    end

    assign done      = done_reg;
    assign count_j   = cnt_j_reg;
    assign count_i   = cnt_i_reg;
    assign count_o   = cnt_o_reg;
    assign bad_query = bad_reg;

endmodule
`default_nettype wire

[src/sarc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sarc_checker: port-level checks of the rectangle counter
// Watches the request, result and configuration ports over time.
// ============================================================================
module sarc_checker
    import sarc_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              mode,
    input wire logic [SIZE_W-1:0] top_row,
    input wire logic [SIZE_W-1:0] left_col,
    input wire logic              done,
    input wire logic [ENT_W-1:0]  count_j,
    input wire logic [ENT_W-1:0]  count_o,
    input wire logic [ENT_W-1:0]  count_i,
    input wire logic              bad_query,
    input wire logic              pready
);

    // A rejected query reports all counts as zero.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && bad_query |-> (count_j == '0) && (count_o == '0) && (count_i == '0))
        else $error("rejected query with nonzero counts");

    // A query starting at row or column zero is rejected in the next cycle.
    a_bad_fast: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && mode && ((top_row == '0) || (left_col == '0))
        |=> done && bad_query)
        else $error("zero-based query not rejected at once");

    // A load request never yields a result in the next cycle.
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !mode |=> !done)
        else $error("result after a load request");

    // A result follows either a query request or a busy cycle.
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || (start && mode)))
        else $error("result without a query in progress");

    // The configuration port never inserts wait states.
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind summed_area_rect_count sarc_checker u_sarc_checker (.*);
`default_nettype wire

[bench/summed_area_rect_count_test.sv]
`timescale 1ns / 1ps
// ============================================================================
// summed_area_rect_count_test: self-checking bench for the rectangle counter
// Streams grid cells and rectangle queries through the start/busy port,
// sizes the grid over APB between phases, and checks every done strobe
// against counts computed from an independent summed-area table.
// ============================================================================
module summed_area_rect_count_test;
    import sarc_pkg::*;

    // Table geometry of the instance under test.
    localparam int GRID_MAX = 1024;
    // Largest value a coordinate or size field can carry.
    localparam int FIELD_TOP = (1 << SIZE_W) - 1;
    // Request modes.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;
    // The class code left unused by the package; the block counts it as O.
    localparam logic [1:0] KIND_SPARE = 2'd3;
    // Cycles allowed after the last result before the grid may be resized.
    // This leaves ample margin for a query or a load still in progress.
    localparam int SETTLE_CYCLES = 12;
    // Number of random requests issued after the directed part; the idle
    // pattern of the sender is spread over this many requests.
    localparam int RANDOM_ITEMS = 1700;

    // One request as it is presented on the input ports.
    typedef struct packed {
        logic              mode;
        logic [1:0]        kind;
        logic [SIZE_W-1:0] first_row;
        logic [SIZE_W-1:0] first_col;
        logic [SIZE_W-1:0] last_row;
        logic [SIZE_W-1:0] last_col;
    } cell_request_t;

    // One answer of a query.
    typedef struct packed {
        logic [ENT_W-1:0] j;
        logic [ENT_W-1:0] o;
        logic [ENT_W-1:0] i;
        logic             bad;
    } rect_counts_t;

    // One prefix entry of the summed-area table, all three classes.
    typedef struct packed {
        logic [ENT_W-1:0] j;
        logic [ENT_W-1:0] i;
        logic [ENT_W-1:0] o;
    } sat_entry_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Request side. The payload ports are all taken from live_req so that a
    // request changes in one nonblocking assignment.
    logic          start = 1'b0;
    cell_request_t live_req = '0;
    logic          busy;

    logic              done;
    logic [ENT_W-1:0]  count_j;
    logic [ENT_W-1:0]  count_o;
    logic [ENT_W-1:0]  count_i;
    logic              bad_query;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    summed_area_rect_count #(
        .MAX_ROWS(GRID_MAX),
        .MAX_COLS(GRID_MAX)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .mode      (live_req.mode),
        .cell_kind (live_req.kind),
        .top_row   (live_req.first_row),
        .left_col  (live_req.first_col),
        .bottom_row(live_req.last_row),
        .right_col (live_req.last_col),
        .done      (done),
        .count_j   (count_j),
        .count_o   (count_o),
        .count_i   (count_i),
        .bad_query (bad_query),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Queues and counters shared by the stimulus, the driver and the monitor.
    // ------------------------------------------------------------------------
    cell_request_t request_q[$];   // requests not yet presented to the block
    rect_counts_t  count_q[$];     // answers owed by the block, oldest first
    int            idle_pct = 18;  // chance, in percent, that the sender idles
    int            taken_cnt = 0;  // requests accepted by the block so far
    int            issued_cnt = 0;
    int            mismatch_cnt = 0;

    // ------------------------------------------------------------------------
    // Independent summed-area table. The position and running sums mirror the
    // block's load pointer; the entries are kept sparse since only small
    // parts of the full table are ever filled.
    // ------------------------------------------------------------------------
    logic [SIZE_W-1:0] cfg_rows = SIZE_RESET;
    logic [SIZE_W-1:0] cfg_cols = SIZE_RESET;
    logic [SUM_W-1:0]  sum_j = '0;
    logic [SUM_W-1:0]  sum_i = '0;
    logic [SUM_W-1:0]  sum_o = '0;
    int                pos_row = 0;
    int                pos_col = 0;
    logic              grid_full = 1'b0;
    sat_entry_t        sat[int];

    // A size of zero means one; anything past the table means the table.
    function automatic int fit_size(input logic [SIZE_W-1:0] v);
        if (v == 0)
        begin
            return 1;
        end
        if (v > GRID_MAX)
        begin
            return GRID_MAX;
        end
        return int'(v);
    endfunction

    // Prefix entry at a one-based position; row and column zero form the
    // zero border of the table.
    function automatic sat_entry_t prefix_at(input int r, input int c);
        int idx;
        if (r == 0 || c == 0)
        begin
            return '0;
        end
        idx = (r - 1) * GRID_MAX + (c - 1);
        if (sat.exists(idx))
        begin
            return sat[idx];
        end
        return '0;
    endfunction

    // Apply one accepted request to the table and queue the answer it owes.
    task automatic commit_request(input cell_request_t req);
        int           rows;
        int           cols;
        int           a;
        int           b;
        int           c;
        int           d;
        logic         bad;
        sat_entry_t   above;
        sat_entry_t   p_cd;
        sat_entry_t   p_ad;
        sat_entry_t   p_cb;
        sat_entry_t   p_ab;
        rect_counts_t res;
        rows = fit_size(cfg_rows);
        cols = fit_size(cfg_cols);
        if (req.mode == MODE_LOAD)
        begin
            // Cells past the end of a complete grid are dropped.
            if (!grid_full && pos_row < rows && pos_col < cols)
            begin
                case (req.kind)
                    KIND_J:  sum_j = sum_j + 1'b1;
                    KIND_I:  sum_i = sum_i + 1'b1;
                    default: sum_o = sum_o + 1'b1;
                endcase
                above = prefix_at(pos_row, pos_col + 1);
                sat[pos_row * GRID_MAX + pos_col] = '{j: above.j + sum_j,
                                                      i: above.i + sum_i,
                                                      o: above.o + sum_o};
                pos_col++;
                if (pos_col >= cols)
                begin
                    pos_col = 0;
                    sum_j = '0;
                    sum_i = '0;
                    sum_o = '0;
                    pos_row++;
                    if (pos_row >= rows)
                    begin
                        grid_full = 1'b1;
                    end
                end
            end
        end
        else
        begin
            a = int'(req.first_row);
            b = int'(req.first_col);
            c = int'(req.last_row);
            d = int'(req.last_col);
            bad = (a == 0 || b == 0 || a > c || b > d || c > rows || d > cols);
            // Until the grid is complete, the bottom right cell must already
            // be loaded; every other corner then comes earlier in row order.
            if (!bad && !grid_full)
            begin
                if ((c - 1) * cols + (d - 1) >= pos_row * cols + pos_col)
                begin
                    bad = 1'b1;
                end
            end
            if (bad)
            begin
                res = '{j: '0, o: '0, i: '0, bad: 1'b1};
            end
            else
            begin
                p_cd = prefix_at(c, d);
                p_ad = prefix_at(a - 1, d);
                p_cb = prefix_at(c, b - 1);
                p_ab = prefix_at(a - 1, b - 1);
                res.j = p_cd.j - p_ad.j - p_cb.j + p_ab.j;
                res.o = p_cd.o - p_ad.o - p_cb.o + p_ab.o;
                res.i = p_cd.i - p_ad.i - p_cb.i + p_ab.i;
                res.bad = 1'b0;
            end
            count_q.push_back(res);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver. A request is taken at an edge where start is high and busy is
    // low; the next one is presented in the same step, or start drops when
    // the sender decides to idle. While busy is high the request is held.
    // The sender idles seldom in the first third of the run, often in the
    // second and never in the last.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                commit_request(live_req);
                taken_cnt++;
            end
            if (taken_cnt < RANDOM_ITEMS / 3)
            begin
                idle_pct = 18;
            end
            else if (taken_cnt < 2 * RANDOM_ITEMS / 3)
            begin
                idle_pct = 82;
            end
            else
            begin
                idle_pct = 0;
            end
            if (!start || !busy)
            begin
                if (request_q.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    live_req <= request_q.pop_front();
                    start <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Each done strobe is matched against the oldest owed answer.
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(input string what, input rect_counts_t want,
                                 input rect_counts_t got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
        begin
            $display("%0t ns: %s: expected j=%0d o=%0d i=%0d bad=%0b,",
                     $realtime, what, want.j, want.o, want.i, want.bad,
                     " got j=%0d o=%0d i=%0d bad=%0b",
                     got.j, got.o, got.i, got.bad);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        rect_counts_t got;
        rect_counts_t want;
        if (rst_n && done)
        begin
            got = '{j: count_j, o: count_o, i: count_i, bad: bad_query};
            if (count_q.size() == 0)
            begin
                flag_mismatch("result with no request waiting", '0, got);
            end
            else
            begin
                want = count_q.pop_front();
                if (got.j !== want.j || got.o !== want.o || got.i !== want.i
                    || got.bad !== want.bad)
                begin
                    flag_mismatch("query answer differs", want, got);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Fields a request does not use still carry random values.
    task automatic queue_load(input logic [1:0] kind);
        cell_request_t req;
        req.mode = MODE_LOAD;
        req.kind = kind;
        req.first_row = SIZE_W'($urandom_range(FIELD_TOP));
        req.first_col = SIZE_W'($urandom_range(FIELD_TOP));
        req.last_row = SIZE_W'($urandom_range(FIELD_TOP));
        req.last_col = SIZE_W'($urandom_range(FIELD_TOP));
        request_q.push_back(req);
        issued_cnt++;
    endtask

    task automatic queue_query(input int a, input int b, input int c, input int d);
        cell_request_t req;
        req.mode = MODE_QUERY;
        req.kind = 2'($urandom_range(3));
        req.first_row = SIZE_W'(a);
        req.first_col = SIZE_W'(b);
        req.last_row = SIZE_W'(c);
        req.last_col = SIZE_W'(d);
        request_q.push_back(req);
        issued_cnt++;
    endtask

    // Waits until every request is taken and answered, then lets the block
    // finish any load still in progress. Polled on the falling edge so the
    // driver's updates of the rising edge have settled.
    task automatic drain_and_wait();
        do
        begin
            @(negedge clk);
        end
        while (request_q.size() != 0 || start || count_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, access cycle, then the edge that commits it.
    // Every write also sends the load pointer back to the first cell.
    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (pready !== 1'b1);
        if (idx == REG_GRID_ROWS)
        begin
            cfg_rows = value[SIZE_W-1:0];
        end
        else
        begin
            cfg_cols = value[SIZE_W-1:0];
        end
        sum_j = '0;
        sum_i = '0;
        sum_o = '0;
        pos_row = 0;
        pos_col = 0;
        grid_full = 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic restart_grid(input logic [31:0] rows_val, input logic [31:0] cols_val);
        drain_and_wait();
        write_reg(REG_GRID_ROWS, rows_val);
        write_reg(REG_GRID_COLS, cols_val);
    endtask

    // Mostly small sizes, with some zero and some oversized values.
    function automatic logic [31:0] pick_size_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
        begin
            return 32'd0;
        end
        if (roll < 20)
        begin
            return 32'($urandom_range(FIELD_TOP, GRID_MAX + 1));
        end
        return 32'($urandom_range(8, 1));
    endfunction

    // One phase: resize the grid, then mix loads with queries. Most queries
    // are well formed over loaded cells; the rest are broken on purpose.
    task automatic run_phase(input logic [31:0] rows_val, input logic [31:0] cols_val,
                             input int n_items, input int load_pct);
        int rows;
        int cols;
        int total;
        int loaded;
        int pick;
        int a;
        int b;
        int c;
        int d;
        restart_grid(rows_val, cols_val);
        rows = fit_size(rows_val[SIZE_W-1:0]);
        cols = fit_size(cols_val[SIZE_W-1:0]);
        total = rows * cols;
        loaded = 0;
        repeat (n_items)
        begin
            if (loaded < total && $urandom_range(99) < load_pct)
            begin
                queue_load(2'($urandom_range(3)));
                loaded++;
            end
            else if (loaded == total && $urandom_range(99) < 5)
            begin
                // The grid is complete, so the block drops this cell.
                queue_load(2'($urandom_range(3)));
            end
            else
            begin
                if (loaded > 0)
                begin
                    pick = $urandom_range(loaded - 1);
                    c = pick / cols + 1;
                    d = pick % cols + 1;
                    a = $urandom_range(c, 1);
                    b = $urandom_range(d, 1);
                end
                else
                begin
                    a = 1;
                    b = 1;
                    c = 1;
                    d = 1;
                end
                if ($urandom_range(99) < 20)
                begin
                    case ($urandom_range(4))
                        0:
                        begin
                            a = $urandom_range(FIELD_TOP);
                            b = $urandom_range(FIELD_TOP);
                            c = $urandom_range(FIELD_TOP);
                            d = $urandom_range(FIELD_TOP);
                        end
                        1:
                        begin
                            if ($urandom_range(1))
                                a = 0;
                            else
                                b = 0;
                        end
                        2:
                        begin
                            if ($urandom_range(1))
                                a = c + 1;
                            else
                                b = d + 1;
                        end
                        3:
                        begin
                            if ($urandom_range(1))
                                c = $urandom_range(FIELD_TOP, rows + 1);
                            else
                                d = $urandom_range(FIELD_TOP, cols + 1);
                        end
                        default:
                        begin
                            // Bottom right corner not loaded yet.
                            if (loaded < total)
                            begin
                                pick = $urandom_range(total - 1, loaded);
                                a = 1;
                                b = 1;
                                c = pick / cols + 1;
                                d = pick % cols + 1;
                            end
                        end
                    endcase
                end
                queue_query(a, b, c, d);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int  random_base;
        int  small_done;
        bit  tall_done;
        bit  wide_done;
        tall_done = 1'b0;
        wide_done = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part on the reset size of 1024 by 1024.
        queue_query(1, 1, 1, 1);                   // nothing loaded yet
        queue_load(KIND_J);
        queue_load(KIND_I);
        queue_load(KIND_O);
        queue_load(KIND_SPARE);                    // unused code counts as O
        queue_load(KIND_J);
        queue_query(1, 1, 1, 5);
        queue_query(1, 2, 1, 3);
        queue_query(1, 1, 1, 6);                   // last cell not loaded
        queue_query(0, 1, 1, 1);                   // starts at row zero
        queue_query(1, 0, 1, 1);                   // starts at column zero
        queue_query(2, 1, 1, 1);                   // rows reversed
        queue_query(1, 3, 1, 2);                   // columns reversed
        queue_query(1, 1, GRID_MAX + 1, 1);        // past the last row
        queue_query(FIELD_TOP, FIELD_TOP, FIELD_TOP, FIELD_TOP);
        queue_query(1, 1, GRID_MAX, GRID_MAX);     // far corner not loaded

        // A one by two grid: a zero row count reads as one, and a third
        // cell lands after the grid is complete.
        restart_grid(32'd0, 32'd2);
        queue_load(KIND_I);
        queue_load(KIND_O);
        queue_load(KIND_J);
        queue_query(1, 1, 1, 2);
        queue_query(1, 2, 1, 2);
        queue_query(1, 1, 1, 3);                   // past the last column
        queue_query(1, 1, 2, 2);                   // past the last row

        // Random part. The first phase also puts junk in the upper bits of
        // the register data, which the block must ignore.
        random_base = issued_cnt;
        run_phase(32'hABCD_0003, 32'hFFFF_F804, 40, 60);
        while (issued_cnt - random_base < RANDOM_ITEMS)
        begin
            small_done = issued_cnt - random_base;
            if (!tall_done && small_done >= 200)
            begin
                // One column, every row of the table, loaded completely.
                run_phase(32'd2047, 32'd1, 1120, 95);
                tall_done = 1'b1;
            end
            else if (!wide_done && small_done >= 1300)
            begin
                // One row as wide as the table, loaded over its first part.
                run_phase(32'd1, 32'd1024, 300, 90);
                wide_done = 1'b1;
            end
            else
            begin
                run_phase(pick_size_value(), pick_size_value(),
                          $urandom_range(60, 20), 60);
            end
        end

        drain_and_wait();
        if (mismatch_cnt == 0 && count_q.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Hard stop in case the block stops answering or stalls for good.
    initial
    begin
        #1000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
